// ===== src/jrc_pkg.sv =====
// ----------------------------------------------------------------------------
// jrc_pkg: joystick response curve shared definitions
// Register indexes, curve codes, default parameters and the request tag that
// travels with every stick sample through the pipeline.
// ----------------------------------------------------------------------------
package jrc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int GUARD_BITS        = 6;
   localparam int TAYLOR_TERMS      = 16;
   localparam int SQUARINGS         = 6;
   localparam int QUO_BITS          = 8;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_MODE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_PARAM = 1'd1;

   localparam logic [2:0] CURVE_LINEAR = 3'd0;
   localparam logic [2:0] CURVE_SQUARE = 3'd1;
   localparam logic [2:0] CURVE_CUBE   = 3'd2;
   localparam logic [2:0] CURVE_EXPO   = 3'd3;
   localparam logic [2:0] CURVE_SCURVE = 3'd4;
   localparam logic [2:0] CURVE_PIECE  = 3'd5;

   localparam logic [15:0] PARAM_MIN      = 16'd41;
   localparam logic [15:0] K_DEFAULT      = 16'd6144;
   localparam logic [15:0] BP_DEFAULT_NUM = 16'd3;
   localparam logic [15:0] BP_DEFAULT_DEN = 16'd10;
   localparam logic [15:0] Q12_DEN        = 16'd4096;
   localparam logic [6:0]  MAG_MAX        = 7'd127;

   typedef struct packed {
      logic [6:0] mag;
      logic       neg;
   } jrc_tag_type;

endpackage

// ===== src/jrc_term_cell.sv =====
// ----------------------------------------------------------------------------
// jrc_term_cell: one Taylor term of e^(-x) on two lanes
// Multiplies the previous term by the argument, divides by the term order
// through a reciprocal and folds the term into the running sum.
// ----------------------------------------------------------------------------
module jrc_term_cell #(
   parameter int WORK_BITS = 22,
   parameter int ORDER     = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  jrc_pkg::jrc_tag_type          in_tag,
   input  logic [1:0][WORK_BITS-1:0]     in_arg,
   input  logic [1:0][WORK_BITS:0]       in_term,
   input  logic [1:0][WORK_BITS+1:0]     in_sum,
   output logic                          out_valid,
   input  logic                          out_ready,
   output jrc_pkg::jrc_tag_type          out_tag,
   output logic [1:0][WORK_BITS-1:0]     out_arg,
   output logic [1:0][WORK_BITS:0]       out_term,
   output logic [1:0][WORK_BITS+1:0]     out_sum
);
   import jrc_pkg::*;

   localparam int W  = WORK_BITS;
   localparam int RS = W + GUARD_BITS;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RS) + 64'(ORDER) - 64'd1) / 64'(ORDER);
   localparam logic [RS:0] RECIP = (RS+1)'(RECIP_FULL);
   localparam bit SUBTRACT = (ORDER % 2) == 1;

   logic                   mid_valid_ff, mid_valid_in, mid_ready;
   jrc_tag_type            mid_tag_ff;
   logic [1:0][W-1:0]      mid_arg_ff;
   logic [1:0][W:0]        mid_prod_ff, mid_prod_in;
   logic [1:0][W+1:0]      mid_sum_ff;
   logic                   out_valid_ff, out_valid_in;
   jrc_tag_type            out_tag_ff;
   logic [1:0][W-1:0]      out_arg_ff;
   logic [1:0][W:0]        out_term_ff, out_term_in;
   logic [1:0][W+1:0]      out_sum_ff, out_sum_in;
   logic [2*W:0]           prod_full [2];
   logic [2*W+7:0]         quo_full [2];

   assign mid_ready    = !out_valid_ff || out_ready;
   assign in_ready     = !mid_valid_ff || mid_ready;
   assign mid_valid_in = in_valid;
   assign out_valid_in = mid_valid_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         prod_full[i]   = (2*W+1)'(in_term[i]) * (2*W+1)'(in_arg[i]);
         mid_prod_in[i] = prod_full[i][2*W:W];
         quo_full[i]    = (2*W+8)'(mid_prod_ff[i]) * (2*W+8)'(RECIP);
         out_term_in[i] = quo_full[i][RS +: W+1];
         if (SUBTRACT) begin
            if ((W+2)'(out_term_in[i]) > mid_sum_ff[i]) begin
               out_sum_in[i] = '0;
            end else begin
               out_sum_in[i] = mid_sum_ff[i] - (W+2)'(out_term_in[i]);
            end
         end else begin
            out_sum_in[i] = mid_sum_ff[i] + (W+2)'(out_term_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mid_valid_ff <= mid_valid_in;
         end
         if (mid_ready) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         mid_tag_ff  <= in_tag;
         mid_arg_ff  <= in_arg;
         mid_prod_ff <= mid_prod_in;
         mid_sum_ff  <= in_sum;
      end
      if (mid_ready) begin
         out_tag_ff  <= mid_tag_ff;
         out_arg_ff  <= mid_arg_ff;
         out_term_ff <= out_term_in;
         out_sum_ff  <= out_sum_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_tag   = out_tag_ff;
   assign out_arg   = out_arg_ff;
   assign out_term  = out_term_ff;
   assign out_sum   = out_sum_ff;

endmodule

// ===== src/jrc_square_cell.sv =====
// ----------------------------------------------------------------------------
// jrc_square_cell: one squaring step on two lanes
// Raises e^(-x/64) towards e^(-x) by repeated squaring, one step per cell.
// ----------------------------------------------------------------------------
module jrc_square_cell #(
   parameter int WORK_BITS = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  jrc_pkg::jrc_tag_type      in_tag,
   input  logic [1:0][WORK_BITS:0]   in_val,
   output logic                      out_valid,
   input  logic                      out_ready,
   output jrc_pkg::jrc_tag_type      out_tag,
   output logic [1:0][WORK_BITS:0]   out_val
);
   import jrc_pkg::*;

   localparam int W = WORK_BITS;

   logic              valid_ff, valid_in;
   jrc_tag_type       tag_ff;
   logic [1:0][W:0]   val_ff, val_in;
   logic [2*W+1:0]    sq_full [2];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sq_full[i] = (2*W+2)'(in_val[i]) * (2*W+2)'(in_val[i]);
         val_in[i]  = sq_full[i][2*W:W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         tag_ff <= in_tag;
         val_ff <= val_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_val   = val_ff;

endmodule

// ===== src/jrc_div_cell.sv =====
// ----------------------------------------------------------------------------
// jrc_div_cell: one bit of a restoring divider
// Compares the partial remainder with the shifted divisor and settles one
// quotient bit.
// ----------------------------------------------------------------------------
module jrc_div_cell #(
   parameter int NUM_BITS = 31,
   parameter int DEN_BITS = 25,
   parameter int BIT      = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  jrc_pkg::jrc_tag_type             in_tag,
   input  logic [NUM_BITS-1:0]              in_rem,
   input  logic [DEN_BITS-1:0]              in_den,
   input  logic [jrc_pkg::QUO_BITS-1:0]     in_quo,
   output logic                             out_valid,
   input  logic                             out_ready,
   output jrc_pkg::jrc_tag_type             out_tag,
   output logic [NUM_BITS-1:0]              out_rem,
   output logic [DEN_BITS-1:0]              out_den,
   output logic [jrc_pkg::QUO_BITS-1:0]     out_quo
);
   import jrc_pkg::*;

   localparam int CW = (NUM_BITS > DEN_BITS + QUO_BITS) ? NUM_BITS : DEN_BITS + QUO_BITS;

   logic                  valid_ff, valid_in;
   jrc_tag_type           tag_ff;
   logic [NUM_BITS-1:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0]   den_ff;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CW-1:0]         shifted, rem_ext;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid;

   always_comb begin
      shifted = CW'(in_den) << BIT;
      rem_ext = CW'(in_rem);
      rem_in  = in_rem;
      quo_in  = in_quo;
      if (rem_ext >= shifted) begin
         rem_in      = NUM_BITS'(rem_ext - shifted);
         quo_in[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         tag_ff <= in_tag;
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

endmodule

// ===== src/joystick_response_curve.sv =====
// Throughput: one request per cycle unless stalled results back up the pipeline;
// every stage holds its own valid bit and fills bubbles, so a stalled result blocks
// intake only once all 51 stages are full. The depth comes from the exponential, 16
// Taylor terms of two stages each and 6 squarings, and from an 8-bit restoring divider of one bit per stage.
// Reset clears all stage valid bits and both configuration registers.
// ----------------------------------------------------------------------------
// joystick_response_curve: stick sample response curve shaper
// Saturates a signed stick sample, shapes its magnitude by the selected curve
// in fixed point and restores the sign.
// ----------------------------------------------------------------------------
module joystick_response_curve #(
   parameter int FRAC_BITS = jrc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [7:0]                     req_stick_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [7:0]                     rsp_shaped_value,
   input  logic                                  csr_write,
   input  logic [jrc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [jrc_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import jrc_pkg::*;

   localparam int W  = FRAC_BITS + GUARD_BITS;
   localparam int NW = W + 9;
   localparam int DW = (W + 3 > 23) ? W + 3 : 23;
   localparam int RECIP127_SHIFT = W + 12;
   localparam longint unsigned RECIP127_FULL =
      ((64'd1 << RECIP127_SHIFT) + 64'd126) / 64'd127;
   localparam logic [W+5:0] RECIP127 = (W+6)'(RECIP127_FULL);
   localparam logic [W:0]   WORK_ONE = (W+1)'(1) << W;
   localparam logic [W-1:0] S_P_ARG  = W'(3) << (W - 6);

   // configuration
   logic [2:0]  curve_mode_ff, curve_mode_in;
   logic [15:0] curve_param_ff, curve_param_in;
   logic        param_used;
   logic [15:0] k_sel, bp_num, bp_den;

   always_comb begin
      curve_mode_in  = curve_mode_ff;
      curve_param_in = curve_param_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CURVE_MODE:  curve_mode_in  = csr_data[2:0];
            CSR_CURVE_PARAM: curve_param_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff  <= '0;
         curve_param_ff <= '0;
      end else begin
         curve_mode_ff  <= curve_mode_in;
         curve_param_ff <= curve_param_in;
      end
   end

   assign param_used = curve_param_ff >= PARAM_MIN;
   assign k_sel  = param_used ? curve_param_ff : K_DEFAULT;
   assign bp_num = param_used ? curve_param_ff : BP_DEFAULT_NUM;
   assign bp_den = param_used ? Q12_DEN : BP_DEFAULT_DEN;

   // stage 0: saturate and form the argument product
   logic        s0_valid_ff, s0_ready;
   jrc_tag_type s0_tag_ff, s0_tag_in;
   logic [22:0] s0_x_ff, s0_x_in;
   logic [7:0]  req_abs;
   logic        s1_ready;

   always_comb begin
      s0_tag_in.neg = req_stick_value[7];
      req_abs = req_stick_value[7] ? 8'(8'd0 - req_stick_value) : req_stick_value;
      s0_tag_in.mag = req_abs[7] ? MAG_MAX : req_abs[6:0];
      if (curve_mode_ff == CURVE_SCURVE) begin
         s0_x_in = (23'(s0_tag_in.mag) * 23'd6) << 12;
      end else begin
         s0_x_in = 23'(k_sel) * 23'(MAG_MAX - s0_tag_in.mag);
      end
   end

   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_tag_ff <= s0_tag_in;
         s0_x_ff   <= s0_x_in;
      end
   end

   // stage 1: scale to the exponent arguments of both lanes
   logic                s1_valid_ff;
   jrc_tag_type         s1_tag_ff;
   logic [1:0][W-1:0]   s1_arg_ff, s1_arg_in;
   logic [W+4:0]        s1_y;
   logic [2*W+10:0]     s1_prod;

   logic [TAYLOR_TERMS:0]              tc_valid, tc_ready;
   jrc_tag_type                        tc_tag [TAYLOR_TERMS+1];
   logic [TAYLOR_TERMS:0][1:0][W-1:0]  tc_arg;
   logic [TAYLOR_TERMS:0][1:0][W:0]    tc_term;
   logic [TAYLOR_TERMS:0][1:0][W+1:0]  tc_sum;

   always_comb begin
      s1_y         = (W+5)'(s0_x_ff) << (W - 18);
      s1_prod      = (2*W+11)'(s1_y) * (2*W+11)'(RECIP127);
      s1_arg_in[0] = W'(s1_prod[2*W+10:RECIP127_SHIFT]);
      if (curve_mode_ff == CURVE_SCURVE) begin
         s1_arg_in[1] = S_P_ARG;
      end else begin
         s1_arg_in[1] = W'(k_sel) << (W - 18);
      end
   end

   assign s1_ready = !s1_valid_ff || tc_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_tag_ff <= s0_tag_ff;
         s1_arg_ff <= s1_arg_in;
      end
   end

   // Taylor series of e^(-x/64)
   assign tc_valid[0] = s1_valid_ff;
   assign tc_tag[0]   = s1_tag_ff;
   assign tc_arg[0]   = s1_arg_ff;
   assign tc_term[0]  = {WORK_ONE, WORK_ONE};
   assign tc_sum[0]   = {(W+2)'(WORK_ONE), (W+2)'(WORK_ONE)};

   for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
      jrc_term_cell #(
         .WORK_BITS (W),
         .ORDER     (g + 1)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (tc_valid[g]),
         .in_ready  (tc_ready[g]),
         .in_tag    (tc_tag[g]),
         .in_arg    (tc_arg[g]),
         .in_term   (tc_term[g]),
         .in_sum    (tc_sum[g]),
         .out_valid (tc_valid[g+1]),
         .out_ready (tc_ready[g+1]),
         .out_tag   (tc_tag[g+1]),
         .out_arg   (tc_arg[g+1]),
         .out_term  (tc_term[g+1]),
         .out_sum   (tc_sum[g+1])
      );
   end

   // six squarings
   logic [SQUARINGS:0]           sq_valid, sq_ready;
   jrc_tag_type                  sq_tag [SQUARINGS+1];
   logic [SQUARINGS:0][1:0][W:0] sq_val;
   logic                         e1_ready;

   assign sq_valid[0]           = tc_valid[TAYLOR_TERMS];
   assign tc_ready[TAYLOR_TERMS] = sq_ready[0];
   assign sq_tag[0]             = tc_tag[TAYLOR_TERMS];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (tc_sum[TAYLOR_TERMS][i] > (W+2)'(WORK_ONE)) begin
            sq_val[0][i] = WORK_ONE;
         end else begin
            sq_val[0][i] = (W+1)'(tc_sum[TAYLOR_TERMS][i]);
         end
      end
   end

   for (genvar g = 0; g < SQUARINGS; g++) begin : g_square
      jrc_square_cell #(
         .WORK_BITS (W)
      ) u_square (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_ready  (sq_ready[g]),
         .in_tag    (sq_tag[g]),
         .in_val    (sq_val[g]),
         .out_valid (sq_valid[g+1]),
         .out_ready (sq_ready[g+1]),
         .out_tag   (sq_tag[g+1]),
         .out_val   (sq_val[g+1])
      );
   end

   assign sq_ready[SQUARINGS] = e1_ready;

   // stage E1: S-curve products and the square of the magnitude
   logic           e1_valid_ff;
   jrc_tag_type    e1_tag_ff;
   logic [W:0]     e1_a_ff, e1_p_ff;
   logic [2*W+1:0] e1_prod1_ff, e1_prod1_in;
   logic [2*W+2:0] e1_prod2_ff, e1_prod2_in;
   logic [13:0]    e1_mm_ff, e1_mm_in;
   logic           e2_ready;

   always_comb begin
      e1_prod1_in = (2*W+2)'(sq_val[SQUARINGS][1]) *
                    (2*W+2)'(WORK_ONE - sq_val[SQUARINGS][0]);
      e1_prod2_in = ((2*W+3)'(sq_val[SQUARINGS][1]) + (2*W+3)'(sq_val[SQUARINGS][0])) *
                    (2*W+3)'(WORK_ONE - sq_val[SQUARINGS][1]);
      e1_mm_in    = 14'(sq_tag[SQUARINGS].mag) * 14'(sq_tag[SQUARINGS].mag);
   end

   assign e1_ready = !e1_valid_ff || e2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (e1_ready) begin
         e1_valid_ff <= sq_valid[SQUARINGS];
      end
   end

   always_ff @(posedge clock) begin
      if (e1_ready) begin
         e1_tag_ff   <= sq_tag[SQUARINGS];
         e1_a_ff     <= sq_val[SQUARINGS][0];
         e1_p_ff     <= sq_val[SQUARINGS][1];
         e1_prod1_ff <= e1_prod1_in;
         e1_prod2_ff <= e1_prod2_in;
         e1_mm_ff    <= e1_mm_in;
      end
   end

   // stage E2: numerator and denominator of the selected curve
   logic          e2_valid_ff;
   jrc_tag_type   e2_tag_ff;
   logic [NW-1:0] e2_num_ff, e2_num_in;
   logic [DW-1:0] e2_den_ff, e2_den_in;
   logic [W+1:0]  s_num;
   logic [W+2:0]  s_den;
   logic [22:0]   pw_md, pw_lim;
   logic [15:0]   pw_span;
   logic [QUO_BITS:0] dv_ready;

   always_comb begin
      s_num   = (W+2)'(e1_prod1_ff >> W);
      s_den   = (W+3)'(e1_prod2_ff >> W);
      pw_md   = 23'(e1_tag_ff.mag) * 23'(bp_den);
      pw_lim  = 23'(bp_num) * 23'd127;
      pw_span = bp_den - bp_num;
      e2_num_in = '0;
      e2_den_in = DW'(1);
      case (curve_mode_ff)
         CURVE_LINEAR: begin
            e2_num_in = NW'(e1_tag_ff.mag);
         end
         CURVE_SQUARE: begin
            e2_num_in = NW'(e1_mm_ff);
            e2_den_in = DW'(127);
         end
         CURVE_CUBE: begin
            e2_num_in = NW'(e1_mm_ff) * NW'(e1_tag_ff.mag);
            e2_den_in = DW'(16129);
         end
         CURVE_EXPO: begin
            if (e1_p_ff < WORK_ONE && e1_a_ff > e1_p_ff) begin
               e2_num_in = NW'(e1_a_ff - e1_p_ff) * NW'(127);
               e2_den_in = DW'(WORK_ONE - e1_p_ff);
            end
         end
         CURVE_SCURVE: begin
            if (s_den != '0) begin
               e2_num_in = NW'(s_num) * NW'(127);
               e2_den_in = DW'(s_den);
            end
         end
         CURVE_PIECE: begin
            if (pw_md <= pw_lim) begin
               e2_num_in = NW'(pw_md) * NW'(15);
               e2_den_in = DW'(bp_num) * DW'(100);
            end else begin
               e2_num_in = NW'(pw_span) * NW'(1905) + NW'(pw_md - pw_lim) * NW'(85);
               e2_den_in = DW'(pw_span) * DW'(100);
            end
         end
         default: ;
      endcase
   end

   assign e2_ready = !e2_valid_ff || dv_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (e2_ready) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e2_ready) begin
         e2_tag_ff <= e1_tag_ff;
         e2_num_ff <= e2_num_in;
         e2_den_ff <= e2_den_in;
      end
   end

   // divider, most significant quotient bit first
   logic [QUO_BITS:0]                 dv_valid;
   jrc_tag_type                       dv_tag [QUO_BITS+1];
   logic [QUO_BITS:0][NW-1:0]         dv_rem;
   logic [QUO_BITS:0][DW-1:0]         dv_den;
   logic [QUO_BITS:0][QUO_BITS-1:0]   dv_quo;
   logic                              out_ready;

   assign dv_valid[0] = e2_valid_ff;
   assign dv_tag[0]   = e2_tag_ff;
   assign dv_rem[0]   = e2_num_ff;
   assign dv_den[0]   = e2_den_ff;
   assign dv_quo[0]   = '0;

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      jrc_div_cell #(
         .NUM_BITS (NW),
         .DEN_BITS (DW),
         .BIT      (QUO_BITS - 1 - g)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_ready  (dv_ready[g]),
         .in_tag    (dv_tag[g]),
         .in_rem    (dv_rem[g]),
         .in_den    (dv_den[g]),
         .in_quo    (dv_quo[g]),
         .out_valid (dv_valid[g+1]),
         .out_ready (dv_ready[g+1]),
         .out_tag   (dv_tag[g+1]),
         .out_rem   (dv_rem[g+1]),
         .out_den   (dv_den[g+1]),
         .out_quo   (dv_quo[g+1])
      );
   end

   assign dv_ready[QUO_BITS] = out_ready;

   // output register: clamp and restore the sign
   logic             rsp_valid_ff;
   logic [7:0]       rsp_value_ff, rsp_value_in;
   logic [6:0]       out_mag;

   always_comb begin
      out_mag = dv_quo[QUO_BITS][QUO_BITS-1] ? MAG_MAX : dv_quo[QUO_BITS][6:0];
      if (dv_tag[QUO_BITS].neg) begin
         rsp_value_in = 8'd0 - {1'b0, out_mag};
      end else begin
         rsp_value_in = {1'b0, out_mag};
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shaped_value = rsp_value_ff;

endmodule
